// ===== hw/rtl/clcd_pkg.sv =====
// Package for the character LCD 4-bit bus controller.
// Holds request codes, bus timing constants and the bus-cycle result type.
// No dependencies.
package clcd_pkg;

  localparam logic [2:0] REQ_INSTR  = 3'd0;
  localparam logic [2:0] REQ_CHAR   = 3'd1;
  localparam logic [2:0] REQ_CURSOR = 3'd2;
  localparam logic [2:0] REQ_INIT   = 3'd3;
  localparam logic [2:0] REQ_BUSY   = 3'd4;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_POLL  = 1'b1;

  localparam logic [13:0] WAIT_STROBE_US = 14'd1;
  localparam logic [13:0] WAIT_INIT0_US  = 14'd15000;
  localparam logic [13:0] WAIT_INIT1_US  = 14'd5000;
  localparam logic [13:0] WAIT_INIT2_US  = 14'd1000;

  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] INSTR_LINE2    = 8'hC0;
  localparam logic [7:0] INSTR_DDRAM    = 8'h80;
  localparam logic [7:0] CURSOR_MASK    = 8'h7F;
  localparam logic [3:0] NIB_INIT_8BIT  = 4'h3;
  localparam logic [3:0] NIB_INIT_4BIT  = 4'h2;
  localparam logic [15:0] MAX_POLLS_RST = 16'd2000;

  typedef struct packed {
    logic        kind;
    logic        rs;
    logic [3:0]  nibble;
    logic [13:0] wait_us;
    logic        tmo;
    logic        last;
  } result_t;

endpackage

// ===== hw/rtl/clcd_step.sv =====
// Request decoder and poll state for the character LCD controller.
// Turns one request into up to four bus-cycle results. Depends on clcd_pkg.
module clcd_step (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take,
  input  logic [2:0]                req_type,
  input  logic [7:0]                value,
  input  logic                      busy_bit,
  input  logic [15:0]               max_polls,
  output logic [2:0]                count,
  output clcd_pkg::result_t [3:0]   res
);

  logic        polling_r, polling_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        rs_r, rs_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] left_dec;
  logic        start;
  logic [7:0]  start_byte;
  logic        start_rs;

  function automatic clcd_pkg::result_t mk(logic kind, logic rs, logic [3:0] nib,
                                           logic [13:0] w, logic tmo, logic last);
    clcd_pkg::result_t r;
    r.kind = kind;
    r.rs = rs;
    r.nibble = nib;
    r.wait_us = w;
    r.tmo = tmo;
    r.last = last;
    return r;
  endfunction

  assign left_dec = (left_r != 16'd0) ? left_r - 16'd1 : left_r;

  always_comb begin
    polling_nxt = polling_r;
    byte_nxt = byte_r;
    rs_nxt = rs_r;
    left_nxt = left_r;
    count = 3'd0;
    start = 1'b0;
    start_byte = value;
    start_rs = 1'b0;
    res[0] = mk(clcd_pkg::KIND_POLL, 1'b0, 4'h0, clcd_pkg::WAIT_STROBE_US, 1'b0, 1'b1);
    res[1] = mk(clcd_pkg::KIND_WRITE, rs_r, byte_r[3:0], clcd_pkg::WAIT_STROBE_US,
                1'b0, 1'b1);
    res[2] = mk(clcd_pkg::KIND_WRITE, 1'b0, clcd_pkg::NIB_INIT_8BIT,
                clcd_pkg::WAIT_INIT2_US, 1'b0, 1'b0);
    res[3] = mk(clcd_pkg::KIND_WRITE, 1'b0, clcd_pkg::NIB_INIT_4BIT,
                clcd_pkg::WAIT_INIT2_US, 1'b0, 1'b1);
    case (req_type)
      clcd_pkg::REQ_BUSY: begin
        if (polling_r) begin
          left_nxt = left_dec;
          if (!busy_bit || left_dec == 16'd0) begin
            count = 3'd2;
            polling_nxt = 1'b0;
            res[0] = mk(clcd_pkg::KIND_WRITE, rs_r, byte_r[7:4],
                        clcd_pkg::WAIT_STROBE_US, busy_bit, 1'b0);
            res[1] = mk(clcd_pkg::KIND_WRITE, rs_r, byte_r[3:0],
                        clcd_pkg::WAIT_STROBE_US, busy_bit, 1'b1);
          end else begin
            count = 3'd1;
          end
        end
      end
      clcd_pkg::REQ_INSTR: begin
        start = !polling_r;
      end
      clcd_pkg::REQ_CHAR: begin
        start = !polling_r;
        if (value == clcd_pkg::CHAR_NEWLINE) begin
          start_byte = clcd_pkg::INSTR_LINE2;
        end else begin
          start_rs = 1'b1;
        end
      end
      clcd_pkg::REQ_CURSOR: begin
        start = !polling_r;
        start_byte = clcd_pkg::INSTR_DDRAM | (value & clcd_pkg::CURSOR_MASK);
      end
      clcd_pkg::REQ_INIT: begin
        if (!polling_r) begin
          count = 3'd4;
          res[0] = mk(clcd_pkg::KIND_WRITE, 1'b0, clcd_pkg::NIB_INIT_8BIT,
                      clcd_pkg::WAIT_INIT0_US, 1'b0, 1'b0);
          res[1] = mk(clcd_pkg::KIND_WRITE, 1'b0, clcd_pkg::NIB_INIT_8BIT,
                      clcd_pkg::WAIT_INIT1_US, 1'b0, 1'b0);
        end
      end
      default: begin
        count = 3'd0;
      end
    endcase
    if (start) begin
      count = 3'd1;
      polling_nxt = 1'b1;
      byte_nxt = start_byte;
      rs_nxt = start_rs;
      left_nxt = (max_polls != 16'd0) ? max_polls : 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polling_r <= 1'b0;
      byte_r <= 8'd0;
      rs_r <= 1'b0;
      left_r <= 16'd0;
    end else if (take) begin
      polling_r <= polling_nxt;
      byte_r <= byte_nxt;
      rs_r <= rs_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

// ===== hw/rtl/clcd_burst.sv =====
// Result buffer and output register for the character LCD controller.
// Holds the bus cycles of one request and sends them one beat at a time.
// Depends on clcd_pkg.
module clcd_burst (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic [2:0]                count,
  input  clcd_pkg::result_t [3:0]   res,
  output logic                      free,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output clcd_pkg::result_t         out_res
);

  clcd_pkg::result_t [3:0] buf_r;
  logic [2:0]        rem_r;
  logic [1:0]        idx_r;
  logic              vld_r;
  clcd_pkg::result_t out_r;
  logic              mv;

  assign mv = (rem_r != 3'd0) && (!vld_r || out_tready);
  assign free = (rem_r == 3'd0) || (rem_r == 3'd1 && mv);
  assign out_tvalid = vld_r;
  assign out_res = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      if (load) begin
        rem_r <= count;
        idx_r <= 2'd0;
      end else if (mv) begin
        rem_r <= rem_r - 3'd1;
        idx_r <= idx_r + 2'd1;
      end
      if (mv) begin
        vld_r <= 1'b1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= res;
    end
    if (mv) begin
      out_r <= buf_r[idx_r];
    end
  end

endmodule

// ===== hw/rtl/char_lcd_4bit_bus_controller.sv =====
// Top level of the character LCD 4-bit bus controller.
// Instantiates clcd_step and clcd_burst; depends on clcd_pkg.
//
// Requests arrive as beats on the in_ channel: in_tuser carries the request
// type and in_tdata the byte and the busy sample. Each request turns into
// zero to four bus-cycle beats on the out_ channel, the last marked by
// out_tlast. With no poll pending, a write request gives one poll beat,
// then each busy sample gives one more poll or the two nibble writes, and
// init gives four writes. A request is held in an input register, decoded
// into a result buffer, and its first beat then moves into the output
// register. The buffer drains one beat per cycle while the receiver is
// ready, and the next request is loaded as the last beat moves out.
// When the receiver stalls, the output register holds its beat, the buffer
// fills up and in_tready drops once the input register is occupied.
// Reset clears all valid flags and the poll state and sets max_polls to
// 2000; cfg_wr_en writes max_polls and is to be used only while idle.
module char_lcd_4bit_bus_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // value[7:0], busy_bit[8], zero pad
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // nibble[3:0], wait_before_us[17:4],
                                  // poll_timed_out[18], zero pad
  output logic [1:0]  out_tuser,  // cycle_kind[0], reg_select[1]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic        in_vld_r;
  logic [2:0]  type_r;
  logic [7:0]  value_r;
  logic        busy_r;
  logic [15:0] max_polls_r;
  logic        take;
  logic        free;
  logic [2:0]  count;
  clcd_pkg::result_t [3:0] res;
  clcd_pkg::result_t       out_res;

  assign take = in_vld_r && free;
  assign in_tready = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      max_polls_r <= clcd_pkg::MAX_POLLS_RST;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (cfg_wr_en) begin
        max_polls_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      type_r <= in_tuser;
      value_r <= in_tdata[7:0];
      busy_r <= in_tdata[8];
    end
  end

  clcd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .req_type  (type_r),
    .value     (value_r),
    .busy_bit  (busy_r),
    .max_polls (max_polls_r),
    .count     (count),
    .res       (res)
  );

  clcd_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take),
    .count      (count),
    .res        (res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {5'd0, out_res.tmo, out_res.wait_us, out_res.nibble};
  assign out_tuser = {out_res.rs, out_res.kind};
  assign out_tlast = out_res.last;

endmodule
